[rtl/core/md5_pkg.sv]
// ----------------------------------------------------------------------------
// md5_pkg
// shared types, codes and constant tables of the md5 digest core
// ----------------------------------------------------------------------------
package md5_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_FINAL = 2'd1,
		KIND_END   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_LOAD,
		ST_COMP,
		ST_FOLD,
		ST_PAD,
		ST_DONE
	} state_t;

	// strobes from the sequencer to the round datapath
	typedef struct packed {
		logic init;
		logic load;
		logic step;
		logic fold;
	} round_ctl_t;

	typedef logic [3:0][31:0] chain_t;

	localparam chain_t InitVector = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

	localparam logic [7:0] PadMarker = 8'h80;

	localparam logic [31:0] RoundK [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] RotAmount [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word index used by a round
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] r;
		logic [3:0] g;
		begin
			r = rnd[3:0];
			case (rnd[5:4])
				2'd0:    g = r;
				2'd1:    g = 4'(r * 4'd5 + 4'd1);
				2'd2:    g = 4'(r * 4'd3 + 4'd5);
				default: g = 4'(r * 4'd7);
			endcase
			return g;
		end
	endfunction

endpackage

[rtl/core/md5_message_digest_top.sv]
// ----------------------------------------------------------------------------
// md5_message_digest_top
// md5 digest of a byte stream, one byte per input transaction
// ----------------------------------------------------------------------------
// input channel s_*: one message byte per transaction, s_tuser gives the kind
// (message byte, final message byte, end of message without byte, unused).
// output channel m_*: one transaction per message, the 16-byte digest.
// bytes are taken one per cycle into a 16-word block buffer. when a block
// fills, s_tready drops for one load step, 64 rounds (one round per cycle, the
// message word read from the registered buffer in the cycle before), one fold.
// at the end of a message the padding is written a word per cycle, followed
// by one or two compressions.
// the digest sits in an output register; if the receiver stalls, the core
// waits in its final state and takes no new byte until the slot is free.
// after the digest the core is back in its initial state.
// reset restores the initial chaining words, clears the byte count and drops
// m_tvalid; the buffer contents are not cleared.
// ----------------------------------------------------------------------------
module md5_message_digest_top
	import md5_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic [1:0]   s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // digest_low, digest_high
);

	state_t      state_q, state_d;
	logic [60:0] count_q;
	logic [5:0]  rnd_q;
	logic [3:0]  pad_word_q;
	logic        first_q, lenblk_q, pad_q, final_q;
	logic        out_valid_q;
	logic [127:0] out_q;

	logic        acc;
	kind_t       kind;
	logic [5:0]  pos;
	logic [60:0] count_inc;
	logic [5:0]  pos_after;
	logic [63:0] bit_len;

	logic        wr_en;
	logic [3:0]  wr_addr, wr_be, rd_addr;
	logic [31:0] wr_data, rd_data;
	logic [31:0] pad_data;
	logic [3:0]  pad_be;
	logic        out_free;

	round_ctl_t  rctl;
	chain_t      chain;

	assign acc       = s_tvalid && s_tready;
	assign kind      = kind_t'(s_tuser);
	assign pos       = count_q[5:0];
	assign count_inc = count_q + 61'd1;
	assign pos_after = (kind == KIND_FINAL) ? count_inc[5:0] : pos;
	assign bit_len   = {count_q, 3'b000};
	assign out_free  = !out_valid_q || m_tready;

	// padding word: marker at the fill position, zeros, length in the last 8 bytes of the last block
	always_comb begin
		logic [5:0] b;
		for (int k = 0; k < 4; k++) begin
			b = {pad_word_q, 2'(k)};
			pad_be[k] = !first_q || (b >= pos);
			if (first_q && b == pos) begin
				pad_data[8*k +: 8] = PadMarker;
			end else if (lenblk_q && b[5:3] == 3'd7) begin
				pad_data[8*k +: 8] = bit_len[8*b[2:0] +: 8];
			end else begin
				pad_data[8*k +: 8] = 8'h00;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (acc) begin
					case (kind)
						KIND_BYTE:  if (pos == 6'd63) state_d = ST_LOAD;
						KIND_FINAL: state_d = (pos == 6'd63) ? ST_LOAD : ST_PAD;
						KIND_END:   state_d = ST_PAD;
						default:    state_d = ST_FILL;
					endcase
				end
			end
			ST_LOAD: state_d = ST_COMP;
			ST_COMP: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (pad_q) begin
					state_d = lenblk_q ? ST_DONE : ST_PAD;
				end else if (final_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_PAD:  if (pad_word_q == 4'd15) state_d = ST_LOAD;
			ST_DONE: if (out_free) state_d = ST_FILL;
			default: state_d = ST_FILL;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = count_q[5:2];
		wr_be    = 4'b0001 << count_q[1:0];
		wr_data  = {4{s_tdata}};
		rd_addr  = 4'd0;
		rctl     = '0;
		unique case (state_q)
			ST_FILL: begin
				s_tready = 1'b1;
				wr_en    = acc && (kind == KIND_BYTE || kind == KIND_FINAL);
			end
			ST_LOAD: begin
				rctl.load = 1'b1;
				rd_addr   = msg_index(6'd0);
			end
			ST_COMP: begin
				rctl.step = 1'b1;
				rd_addr   = msg_index(6'(rnd_q + 6'd1));
			end
			ST_FOLD: rctl.fold = 1'b1;
			ST_PAD: begin
				wr_en   = 1'b1;
				wr_addr = pad_word_q;
				wr_be   = pad_be;
				wr_data = pad_data;
			end
			ST_DONE: rctl.init = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			count_q     <= '0;
			rnd_q       <= '0;
			pad_word_q  <= '0;
			first_q     <= 1'b0;
			lenblk_q    <= 1'b0;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_FILL: begin
					if (acc && (kind == KIND_BYTE || kind == KIND_FINAL)) count_q <= count_inc;
					final_q <= acc && (kind == KIND_FINAL);
					pad_q   <= 1'b0;
					// first padding pass starts at the word holding the marker
					pad_word_q <= pos_after[5:2];
					first_q    <= 1'b1;
					lenblk_q   <= (pos_after[5:3] != 3'd7);
				end
				ST_LOAD: rnd_q <= '0;
				ST_COMP: rnd_q <= rnd_q + 6'd1;
				ST_FOLD: begin
					if (pad_q) begin
						// second pass: zeros and length only
						pad_word_q <= '0;
						first_q    <= 1'b0;
						lenblk_q   <= 1'b1;
					end else begin
						pad_word_q <= '0;
						first_q    <= 1'b1;
						lenblk_q   <= 1'b1;
					end
					pad_q   <= 1'b0;
					final_q <= 1'b0;
				end
				ST_PAD: begin
					pad_word_q <= pad_word_q + 4'd1;
					if (pad_word_q == 4'd15) pad_q <= 1'b1;
				end
				ST_DONE: begin
					if (out_free) begin
						count_q     <= '0;
						pad_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// output slot: filled from the final state, emptied by the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= {chain[3], chain[2], chain[1], chain[0]};
		end
	end

	md5_msg_buf u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_be   (wr_be),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	md5_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.rnd    (rnd_q),
		.w      (rd_data),
		.chain  (chain)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

[rtl/core/md5_msg_buf.sv]
// ----------------------------------------------------------------------------
// md5_msg_buf
// 16 x 32-bit block buffer, byte-lane writes, registered read
// ----------------------------------------------------------------------------
module md5_msg_buf (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [3:0]  wr_addr,
	input  logic [3:0]  wr_be,
	input  logic [31:0] wr_data,
	input  logic [3:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < 4; k++) begin
				if (wr_be[k]) begin
					mem[wr_addr][8*k +: 8] <= wr_data[8*k +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/core/md5_round.sv]
// ----------------------------------------------------------------------------
// md5_round
// chaining words and working words, one compression round per step
// ----------------------------------------------------------------------------
module md5_round
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  round_ctl_t  ctl,
	input  logic [5:0]  rnd,
	input  logic [31:0] w,
	output chain_t      chain
);

	chain_t      chain_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f, t, rot;
	logic [63:0] dbl;

	always_comb begin
		case (rnd[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (d_q & b_q) | (~d_q & c_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t   = a_q + f + w + RoundK[rnd];
		dbl = {t, t} << RotAmount[{rnd[5:4], rnd[1:0]}];
		rot = dbl[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= InitVector;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
		end else if (ctl.init) begin
			chain_q <= InitVector;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
		end else if (ctl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (ctl.step) begin
			a_q <= d_q;
			b_q <= b_q + rot;
			c_q <= b_q;
			d_q <= c_q;
		end else if (ctl.fold) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
	end

	assign chain = chain_q;

endmodule

[bench/tb_md5_message_digest_top.sv]
// ----------------------------------------------------------------------------
// tb_md5_message_digest_top
// self-checking bench for the md5 digest core
// ----------------------------------------------------------------------------
// byte transactions go in on the s_* side with random gaps. a digest model
// inside the bench pads and compresses the same bytes and queues the digest
// each message should give. every m_* transaction is checked against the
// oldest queued digest. covered: empty messages, unused kinds, padding that
// needs a second block, output stalls that back up the input, and random
// messages with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_md5_message_digest_top;
	import md5_pkg::*;

	localparam int ItemTarget = 1250;
	localparam int StallLimit = 2000;
	localparam int TailCycles = 200;
	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] InitChain [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [31:0] SineTable [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ShiftTable [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	// message lengths around the padding boundaries
	localparam int PadLengths [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} digest_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // data_byte
	logic [1:0]   s_tuser;   // kind
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // digest_low, digest_high

	// digest model state
	logic [7:0]  msg_block [64];
	logic [31:0] chain_state [4];
	logic [60:0] byte_total;

	digest_t digests_pending [$];
	int      items_sent = 0;
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      rx_hold = 0;
	bit      tx_steady = 1'b0;
	bit      rx_steady = 1'b0;

	md5_message_digest_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void md5_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t, rot;
		int g;
		int s;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
		a = chain_state[0];
		b = chain_state[1];
		c = chain_state[2];
		d = chain_state[3];
		for (int i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			s = ShiftTable[(i / 16) * 4 + i % 4];
			t = a + f + w[g] + SineTable[i];
			rot = (t << s) | (t >> (32 - s));
			a = d;
			d = c;
			c = b;
			b = b + rot;
		end
		chain_state[0] = chain_state[0] + a;
		chain_state[1] = chain_state[1] + b;
		chain_state[2] = chain_state[2] + c;
		chain_state[3] = chain_state[3] + d;
	endfunction

	// feed one accepted transaction into the digest model
	function automatic void digest_absorb(input kind_t kind, input logic [7:0] data_byte);
		logic [63:0] bit_len;
		int pos;
		if (kind == KIND_NONE)
			return;
		if (kind != KIND_END) begin
			msg_block[byte_total[5:0]] = data_byte;
			byte_total = byte_total + 61'd1;
			if (byte_total[5:0] == 6'd0)
				md5_compress();
		end
		if (kind == KIND_BYTE)
			return;
		bit_len = {byte_total, 3'b000};
		pos = byte_total[5:0];
		msg_block[pos] = PadByte;
		pos++;
		// no room for the length field, pad out and compress an extra block
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			md5_compress();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56 + i] = bit_len[8*i +: 8];
		md5_compress();
		digests_pending.push_back({chain_state[3], chain_state[2], chain_state[1], chain_state[0]});
		chain_state = InitChain;
		byte_total = '0;
	endfunction

	function automatic logic [7:0] random_byte();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hff;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_item(input kind_t kind, input logic [7:0] data_byte);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data_byte;
		do @(posedge clk); while (!s_tready);
		digest_absorb(kind, data_byte);
		if (kind != KIND_NONE)
			items_sent++;
	endtask

	task automatic send_message(input int len, input bit end_on_byte, input bit noisy);
		for (int n = 0; n < len; n++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_item(KIND_NONE, random_byte());
			if (end_on_byte && n == len - 1)
				send_item(KIND_FINAL, random_byte());
			else
				send_item(KIND_BYTE, random_byte());
		end
		if (!end_on_byte || len == 0)
			send_item(KIND_END, random_byte());
	endtask

	task automatic wait_for_digests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digests_pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		// empty messages (byte field ignored), one-byte messages and a three-byte one
		send_item(KIND_END, 8'hff);
		send_item(KIND_END, 8'h00);
		send_item(KIND_FINAL, 8'h00);
		send_item(KIND_FINAL, 8'hff);
		send_item(KIND_BYTE, 8'h61);
		send_item(KIND_BYTE, 8'h62);
		send_item(KIND_FINAL, 8'h63);
		// unused kind between messages and inside one
		send_item(KIND_NONE, 8'hff);
		send_item(KIND_NONE, 8'h00);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_NONE, 8'haa);
		send_item(KIND_BYTE, 8'hff);
		send_item(KIND_END, 8'h55);
		wait_for_digests();
	endtask

	task automatic test_drain_pause();
		send_message(5, 1'b1, 1'b0);
		wait_for_digests();
		send_message(64, 1'b0, 1'b0);
		wait_for_digests();
	endtask

	task automatic test_output_stall();
		// receiver holds off while short messages pile up behind the digest slot
		rx_hold = 300;
		for (int n = 0; n < 4; n++)
			send_message($urandom_range(0, 3), 1'($urandom_range(0, 1)), 1'b0);
		send_message(70, 1'b0, 1'b0);
		wait_for_digests();
	endtask

	task automatic test_random_messages();
		int len;
		int pick;
		foreach (PadLengths[j]) begin
			send_message(PadLengths[j], 1'($urandom_range(0, 1)), 1'b0);
		end
		while (items_sent < ItemTarget) begin
			pick = $urandom_range(0, 9);
			tx_steady = ($urandom_range(0, 5) == 0);
			rx_steady = ($urandom_range(0, 5) == 0);
			if (pick < 5)
				len = $urandom_range(0, 20);
			else if (pick < 8)
				len = PadLengths[$urandom_range(0, 9)];
			else
				len = $urandom_range(21, 130);
			send_message(len, 1'($urandom_range(0, 1)), 1'b1);
			if ($urandom_range(0, 7) == 0)
				wait_for_digests();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver: random stall per digest, long hold when requested
	initial begin : digest_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 5);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				do @(posedge clk); while (!m_tvalid && rx_hold == 0);
			end
		end
	end

	always @(posedge clk) begin : digest_check
		digest_t expected;
		if (arst_n && m_tvalid && m_tready) begin
			if (digests_pending.size() == 0) begin
				$display("%0t: unexpected digest transaction, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				expected = digests_pending.pop_front();
				if (m_tdata[63:0] !== expected.digest_low) begin
					$display("%0t: digest_low mismatch, expected %h, actual %h",
						$time, expected.digest_low, m_tdata[63:0]);
					mismatches++;
				end
				if (m_tdata[127:64] !== expected.digest_high) begin
					$display("%0t: digest_high mismatch, expected %h, actual %h",
						$time, expected.digest_high, m_tdata[127:64]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = KIND_NONE;
		s_tdata  = 8'h00;
		chain_state = InitChain;
		byte_total  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_drain_pause();
		test_output_stall();
		test_random_messages();
		wait_for_digests();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
